// ----- rtl/gregorian_date_add_days_assert.svh -----
// Assertion macros for the date adder
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is held
`define GDAD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdad assertion failed");
// clocked check that also covers the reset cycles
`define GDAD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gdad reset assertion failed");
`else
`define GDAD_ASSERT(lbl, prop)
`define GDAD_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- rtl/gdad_pkg.sv -----
`default_nettype none

package gdad_pkg;

  localparam int YEAR_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int SWEEP_W    = $clog2(YEAR_BITS);
  localparam int R400_W     = 9;
  localparam int LEAP_CYCLE = 400;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 32;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_SWEEP,
    OP_CHECK,
    OP_ADV,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SWEEP_MORE,
    COND_BAD_DATE,
    COND_ADV_MORE,
    COND_OUT_FULL
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } uword_t;

  localparam upc_t STEP_WAIT  = 3'd0;
  localparam upc_t STEP_SWEEP = 3'd1;
  localparam upc_t STEP_CHECK = 3'd2;
  localparam upc_t STEP_ADV   = 3'd3;
  localparam upc_t STEP_EMIT  = 3'd4;
  localparam upc_t STEP_BACK  = 3'd5;

  // microprogram: jump to target when the condition holds, else fall through
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_NO_INPUT,   target: STEP_WAIT};
      STEP_SWEEP: w = '{op: OP_SWEEP, cond: COND_SWEEP_MORE, target: STEP_SWEEP};
      STEP_CHECK: w = '{op: OP_CHECK, cond: COND_BAD_DATE,   target: STEP_EMIT};
      STEP_ADV:   w = '{op: OP_ADV,   cond: COND_ADV_MORE,   target: STEP_ADV};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_FULL,   target: STEP_EMIT};
      default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // leap test from year mod 400 and the two low year bits
  function automatic logic is_leap(input logic [R400_W-1:0] r400, input logic [1:0] ylo);
    logic cent;
    cent = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (r400 == '0) || ((ylo == 2'b00) && !cent);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gregorian_date_add_days.sv -----
// Gregorian date adder.
// Input stream (in_*): one transfer carries a start date and a day count.
// Output stream (out_*): one transfer per input with the resulting date and
// the valid and year-overflow flags. An invalid start date comes back
// unchanged with date_valid low.
// Each item is run by a six-step microprogram: take the transfer, form the
// year mod 400 for the leap test by sweeping the year bits one per step,
// check the date (an invalid one goes straight to output), advance one
// month per step until the remaining count fits in the current month and
// add it to the day, move the result into the output register and return
// to idle. Only one item is in work at a time.
// The output register parts the two sides: a new item is taken while a
// result waits; a stalled receiver holds the sequencer at the output step
// only once the next result is ready.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// out_tvalid.
`default_nettype none
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // day_in[4:0], month_in[8:5], year_in[24:9], days_to_add[40:25], zero fill
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // day_out[4:0], month_out[8:5], year_out[24:9], date_valid[25],
  // year_overflow[26], zero fill
  output logic [OUT_W-1:0]      out_tdata
);

  upc_t                  pc_r, pc_nxt;
  uword_t                uw;
  logic                  cond_hit;

  logic [4:0]            day_r, day_nxt;
  logic [3:0]            month_r, month_nxt;
  logic [YEAR_BITS-1:0]  year_r, year_nxt;
  logic [YEAR_BITS-1:0]  sh_r, sh_nxt;
  logic [SWEEP_W-1:0]    cnt_r, cnt_nxt;
  logic [R400_W-1:0]     r400_r, r400_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic                  valid_r, valid_nxt;
  logic                  wrap_r, wrap_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [4:0]            out_day_r, out_day_nxt;
  logic [3:0]            out_month_r, out_month_nxt;
  logic [YEAR_BITS-1:0]  out_year_r, out_year_nxt;
  logic                  out_dv_r, out_dv_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  in_xfer;
  logic                  out_full;
  logic [4:0]            cur_len;
  logic [4:0]            left;
  logic                  fits;
  logic                  date_ok;
  logic [R400_W:0]       r400_sh;
  logic [R400_W:0]       r400_red;

  assign uw       = ucode_rom(pc_r);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_full = out_valid_r && !out_tready;

  assign cur_len  = month_len(month_r, is_leap(r400_r, year_r[1:0]));
  assign left     = cur_len - day_r;
  assign fits     = rem_r <= COUNT_BITS'(left);
  assign date_ok  = (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC) &&
                    (day_r != 5'd0) && (day_r <= cur_len);
  assign r400_sh  = {r400_r, sh_r[YEAR_BITS-1]};
  assign r400_red = (r400_sh >= (R400_W+1)'(LEAP_CYCLE)) ?
                    r400_sh - (R400_W+1)'(LEAP_CYCLE) : r400_sh;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_NO_INPUT:   cond_hit = !in_xfer;
      COND_SWEEP_MORE: cond_hit = cnt_r != '0;
      COND_BAD_DATE:   cond_hit = !date_ok;
      COND_ADV_MORE:   cond_hit = !fits;
      COND_OUT_FULL:   cond_hit = out_full;
      default:         cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? uw.target : pc_r + upc_t'(1);
  end

  assign in_tready = uw.op == OP_WAIT;

  always_comb begin
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    r400_nxt      = r400_r;
    rem_nxt       = rem_r;
    valid_nxt     = valid_r;
    wrap_nxt      = wrap_r;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_dv_nxt    = out_dv_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_full;
    unique case (uw.op)
      OP_WAIT: begin
        if (in_xfer) begin
          day_nxt   = in_tdata[4:0];
          month_nxt = in_tdata[8:5];
          year_nxt  = YEAR_BITS'(in_tdata[24:9]);
          sh_nxt    = YEAR_BITS'(in_tdata[24:9]);
          rem_nxt   = COUNT_BITS'(in_tdata[40:25]);
          cnt_nxt   = SWEEP_W'(YEAR_BITS - 1);
          r400_nxt  = '0;
          valid_nxt = 1'b0;
          wrap_nxt  = 1'b0;
        end
      end
      OP_SWEEP: begin
        r400_nxt = r400_red[R400_W-1:0];
        sh_nxt   = {sh_r[YEAR_BITS-2:0], 1'b0};
        cnt_nxt  = cnt_r - SWEEP_W'(1);
      end
      OP_CHECK: begin
        valid_nxt = date_ok;
      end
      OP_ADV: begin
        if (fits) begin
          day_nxt = day_r + rem_r[4:0];
          rem_nxt = '0;
        end else begin
          rem_nxt = rem_r - COUNT_BITS'(left) - COUNT_BITS'(1);
          day_nxt = 5'd1;
          if (month_r == MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            if (year_r == '1) begin
              year_nxt = '0;
              r400_nxt = '0;
              wrap_nxt = 1'b1;
            end else begin
              year_nxt = year_r + YEAR_BITS'(1);
              r400_nxt = (r400_r == R400_W'(LEAP_CYCLE - 1)) ? '0 : r400_r + R400_W'(1);
            end
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = day_r;
          out_month_nxt = month_r;
          out_year_nxt  = year_r;
          out_dv_nxt    = valid_r;
          out_ovf_nxt   = wrap_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r       <= day_nxt;
    month_r     <= month_nxt;
    year_r      <= year_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    r400_r      <= r400_nxt;
    rem_r       <= rem_nxt;
    valid_r     <= valid_nxt;
    wrap_r      <= wrap_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_dv_r    <= out_dv_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_ovf_r, out_dv_r, 16'(out_year_r), out_month_r, out_day_r};

  `GDAD_ASSERT_RST(a_reset_idle, !rst_n |=> (pc_r == STEP_WAIT) && !out_tvalid)
  `GDAD_ASSERT(a_leave_idle, in_tvalid && in_tready |=> pc_r == STEP_SWEEP)
  `GDAD_ASSERT(a_adv_date_ok, (uw.op == OP_ADV) |-> date_ok && valid_r)
  `GDAD_ASSERT(a_r400_range, (uw.op == OP_ADV) |-> r400_r < R400_W'(LEAP_CYCLE))
  `GDAD_ASSERT(a_wrap_needs_valid, (uw.op == OP_EMIT) && wrap_r |-> valid_r)

endmodule

`default_nettype wire
